// ----- hdl/stvs_pkg.sv -----
// Shared types and constants for the swept-tone voice synthesizer.
// No dependencies; every other file in hdl/ refers to this package.
package stvs_pkg;

  localparam int SINE_TABLE_DEPTH_DEFAULT = 1024;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int SINE_MAX = 32767;

  localparam int SAMPLE_W    = 16;
  localparam int COUNT_W     = 16;
  localparam int INC_W       = 32;
  localparam int AMP_W       = 15;
  localparam int FRAC_W      = 16;
  localparam int MAG_W       = 16;
  localparam int ROM_W       = 15;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;

  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 16'd3273;
  localparam logic [INC_W-1:0]   INC_RESET   = 32'd58982400;
  localparam logic [AMP_W-1:0]   AMP_RESET   = 15'd9830;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SAMPLE_COUNT = 3'd0,
    REG_START_INC    = 3'd1,
    REG_END_INC      = 3'd2,
    REG_AMPLITUDE    = 3'd3,
    REG_SQUARE_MODE  = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_INC,
    S_ENV_Q,
    S_ENV_A,
    S_MAG,
    S_AMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] product;
  } mul_rsp_t;

endpackage

// ----- hdl/stvs_if.sv -----
// Handshake channels of the voice: tick beats in, sample beats out.
// Depends on stvs_pkg for field widths.
interface stvs_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface stvs_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [stvs_pkg::SAMPLE_W-1:0] sample;
  logic                                 last;
  logic                                 active;

  modport source (output valid, output sample, output last, output active, input ready);
  modport sink   (input valid, input sample, input last, input active, output ready);
endinterface

// ----- hdl/swept_tone_voice_synth.sv -----
// Swept-tone voice: linear chirp oscillator with envelope, one sample per tick beat.
// Uses stvs_pkg, stvs_if, stvs_div, stvs_mul and stvs_sine_rom.
//
//   channel  dir  fields                  beat
//   tick     in   restart                 valid & ready
//   result   out  sample, last, active    valid & ready
//   cfg      in   cfg_index, cfg_wr_data  cfg_wr_en
//
// A cue sample runs a 16-step divider for the sweep position, then five 17-step
// passes through the one shared serial multiplier.
// Reset is synchronous and leaves the voice idle.
// A tick is taken only when the sequencer is idle; one finished beat waits in the
// output register, so a stalled result blocks only the completion of the next tick.
module swept_tone_voice_synth #(
  parameter int SINE_TABLE_DEPTH = stvs_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [stvs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [stvs_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
  stvs_tick_if.sink                          tick,
  stvs_result_if.source                      result
);

  localparam int AddrW = $clog2(SINE_TABLE_DEPTH) + 1;
  localparam int PosW  = 30 + AddrW;

  stvs_pkg::state_t state, state_next;

  logic [stvs_pkg::COUNT_W-1:0] sample_count;
  logic [stvs_pkg::INC_W-1:0]   start_inc;
  logic [stvs_pkg::INC_W-1:0]   end_inc;
  logic [stvs_pkg::AMP_W-1:0]   amplitude;
  logic                         square_mode;

  logic [stvs_pkg::INC_W-1:0]   phase_acc;
  logic [stvs_pkg::COUNT_W-1:0] sample_index;
  logic                         running;
  logic [stvs_pkg::FRAC_W-1:0]  p_reg;
  logic                         neg;

  logic [stvs_pkg::SAMPLE_W-1:0] res_sample;
  logic                          res_last;
  logic                          res_active;

  logic                          out_valid;
  logic [stvs_pkg::SAMPLE_W-1:0] out_sample;
  logic                          out_last;
  logic                          out_active;

  logic [stvs_pkg::COUNT_W-1:0] count_eff;
  logic                         idle_tick;
  logic                         dir_down;
  logic [stvs_pkg::INC_W-1:0]   diff;
  logic [stvs_pkg::INC_W-1:0]   t_val;
  logic [stvs_pkg::INC_W-1:0]   inc_val;
  logic [stvs_pkg::COUNT_W:0]   index_inc;
  logic                         is_last;
  logic [stvs_pkg::FRAC_W:0]    q_val;
  logic [19:0]                  nine_p;
  logic [stvs_pkg::MAG_W-1:0]   a_env;
  logic [stvs_pkg::MAG_W-1:0]   mag_val;
  logic                         neg_val;
  logic [45:0]                  m_val;
  logic [60:0]                  m_scaled;
  logic [stvs_pkg::SAMPLE_W-1:0] res_mag;
  logic                          load_out;

  logic                         div_start;
  logic                         div_done;
  logic [stvs_pkg::FRAC_W-1:0]  div_quot;
  stvs_pkg::mul_req_t           mul_req;
  stvs_pkg::mul_rsp_t           mul_rsp;

  logic [PosW-1:0]              pos_prod;
  logic [AddrW-1:0]             pos;
  logic [AddrW-1:0]             rom_addr;
  logic [stvs_pkg::ROM_W-1:0]   rom_data;

  stvs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (sample_index),
    .denom (count_eff),
    .done  (div_done),
    .quot  (div_quot)
  );

  stvs_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  stvs_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  // sweep and phase
  assign count_eff = (sample_count == '0) ? stvs_pkg::COUNT_W'(1) : sample_count;
  assign idle_tick = !running || (sample_index >= count_eff);
  assign dir_down  = end_inc < start_inc;
  assign diff      = dir_down ? (start_inc - end_inc) : (end_inc - start_inc);
  assign t_val     = mul_rsp.product[47:16];
  assign inc_val   = dir_down ? (start_inc - t_val) : (start_inc + t_val);
  assign index_inc = {1'b0, sample_index} + 17'd1;
  assign is_last   = index_inc >= {1'b0, count_eff};

  // envelope
  assign q_val  = 17'h10000 - {1'b0, p_reg};
  assign nine_p = {1'b0, p_reg, 3'b000} + {4'b0000, p_reg};
  assign a_env  = (nine_p > 20'd32768) ? 16'h8000 : nine_p[15:0];

  // table lookup
  assign pos_prod = PosW'(phase_acc[29:0]) * PosW'(SINE_TABLE_DEPTH);
  assign pos      = pos_prod[PosW-1:30];
  assign rom_addr = phase_acc[30] ? (AddrW'(SINE_TABLE_DEPTH) - pos) : pos;
  assign neg_val  = phase_acc[31] && (rom_data != '0);
  assign mag_val  = square_mode ? 16'h8000 : {1'b0, rom_data};

  // final scale by 32767, truncated
  assign m_val    = mul_rsp.product[45:0];
  assign m_scaled = {m_val, 15'b0} - {15'b0, m_val};
  assign res_mag  = m_scaled[60:45];

  assign load_out = (state == stvs_pkg::S_DONE) && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stvs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    tick.ready  = 1'b0;
    div_start   = 1'b0;
    mul_req     = '0;
    unique case (state)
      stvs_pkg::S_IDLE: begin
        tick.ready = 1'b1;
        if (tick.valid) state_next = stvs_pkg::S_CHECK;
      end
      stvs_pkg::S_CHECK: begin
        if (idle_tick) begin
          state_next = stvs_pkg::S_DONE;
        end else begin
          div_start  = 1'b1;
          state_next = stvs_pkg::S_DIV;
        end
      end
      stvs_pkg::S_DIV: begin
        if (div_done) begin
          mul_req.start = 1'b1;
          mul_req.a     = diff;
          mul_req.b     = {1'b0, div_quot};
          state_next    = stvs_pkg::S_INC;
        end
      end
      stvs_pkg::S_INC: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = {15'b0, q_val};
          mul_req.b     = q_val;
          state_next    = stvs_pkg::S_ENV_Q;
        end
      end
      stvs_pkg::S_ENV_Q: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = {16'b0, a_env};
          mul_req.b     = {1'b0, mul_rsp.product[32:17]};
          state_next    = stvs_pkg::S_ENV_A;
        end
      end
      stvs_pkg::S_ENV_A: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = {16'b0, mag_val};
          mul_req.b     = {1'b0, mul_rsp.product[30:15]};
          state_next    = stvs_pkg::S_MAG;
        end
      end
      stvs_pkg::S_MAG: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = {1'b0, mul_rsp.product[30:0]};
          mul_req.b     = {2'b00, amplitude};
          state_next    = stvs_pkg::S_AMP;
        end
      end
      stvs_pkg::S_AMP: begin
        if (mul_rsp.done) state_next = stvs_pkg::S_DONE;
      end
      stvs_pkg::S_DONE: begin
        if (!out_valid || result.ready) state_next = stvs_pkg::S_IDLE;
      end
      default: state_next = stvs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= stvs_pkg::COUNT_RESET;
      start_inc    <= stvs_pkg::INC_RESET;
      end_inc      <= stvs_pkg::INC_RESET;
      amplitude    <= stvs_pkg::AMP_RESET;
      square_mode  <= 1'b0;
      phase_acc    <= '0;
      sample_index <= '0;
      running      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (stvs_pkg::cfg_reg_t'(cfg_index))
          stvs_pkg::REG_SAMPLE_COUNT: sample_count <= cfg_wr_data[stvs_pkg::COUNT_W-1:0];
          stvs_pkg::REG_START_INC:    start_inc    <= cfg_wr_data[stvs_pkg::INC_W-1:0];
          stvs_pkg::REG_END_INC:      end_inc      <= cfg_wr_data[stvs_pkg::INC_W-1:0];
          stvs_pkg::REG_AMPLITUDE:    amplitude    <= cfg_wr_data[stvs_pkg::AMP_W-1:0];
          stvs_pkg::REG_SQUARE_MODE:  square_mode  <= cfg_wr_data[0];
          default: ;
        endcase
      end
      case (state)
        stvs_pkg::S_IDLE: begin
          if (tick.valid && tick.restart) begin
            phase_acc    <= '0;
            sample_index <= '0;
            running      <= 1'b1;
          end
        end
        stvs_pkg::S_CHECK: begin
          if (idle_tick) begin
            running    <= 1'b0;
            res_sample <= '0;
            res_last   <= 1'b0;
            res_active <= 1'b0;
          end
        end
        stvs_pkg::S_DIV: begin
          if (div_done) p_reg <= div_quot;
        end
        stvs_pkg::S_INC: begin
          if (mul_rsp.done) begin
            phase_acc    <= phase_acc + inc_val;
            sample_index <= index_inc[stvs_pkg::COUNT_W-1:0];
            res_last     <= is_last;
            if (is_last) running <= 1'b0;
          end
        end
        stvs_pkg::S_ENV_A: begin
          if (mul_rsp.done) neg <= neg_val;
        end
        stvs_pkg::S_AMP: begin
          if (mul_rsp.done) begin
            res_sample <= neg ? (~res_mag + 16'd1) : res_mag;
            res_active <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample <= res_sample;
      out_last   <= res_last;
      out_active <= res_active;
    end
  end

  assign result.valid  = out_valid;
  assign result.sample = out_sample;
  assign result.last   = out_last;
  assign result.active = out_active;

endmodule

// ----- hdl/stvs_div.sv -----
// Radix-2 restoring divider: quot = floor(numer * 2^16 / denom), numer < denom.
// One quotient bit per cycle. Depends on stvs_pkg.
module stvs_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [stvs_pkg::COUNT_W-1:0]  numer,
  input  logic [stvs_pkg::COUNT_W-1:0]  denom,
  output logic                          done,
  output logic [stvs_pkg::FRAC_W-1:0]   quot
);

  localparam int CntW = $clog2(stvs_pkg::FRAC_W);

  logic [stvs_pkg::COUNT_W-1:0] rem;
  logic [stvs_pkg::COUNT_W-1:0] dvs;
  logic [CntW-1:0]              cnt;
  logic                         busy;
  logic [stvs_pkg::COUNT_W:0]   rem2;
  logic [stvs_pkg::COUNT_W:0]   rem_sub;
  logic                         ge;

  assign rem2    = {rem, 1'b0};
  assign ge      = rem2 >= {1'b0, dvs};
  assign rem_sub = rem2 - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= numer;
        dvs  <= denom;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? rem_sub[stvs_pkg::COUNT_W-1:0] : rem2[stvs_pkg::COUNT_W-1:0];
        quot <= {quot[stvs_pkg::FRAC_W-2:0], ge};
        cnt  <= cnt + 1'b1;
        if (cnt == CntW'(stvs_pkg::FRAC_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/stvs_mul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Shared by the sweep, envelope and amplitude products; the table position is computed apart. Depends on stvs_pkg.
module stvs_mul (
  input  logic               clk,
  input  logic               rst,
  input  stvs_pkg::mul_req_t req,
  output stvs_pkg::mul_rsp_t rsp
);

  localparam int AW   = stvs_pkg::MUL_A_W;
  localparam int BW   = stvs_pkg::MUL_B_W;
  localparam int PW   = stvs_pkg::MUL_P_W;
  localparam int CntW = $clog2(BW);

  logic [AW-1:0]   a_reg;
  logic [PW-1:0]   acc;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic            done_r;
  logic [AW:0]     sum;

  assign sum = {1'b0, acc[PW-1:BW]} + (acc[0] ? {1'b0, a_reg} : '0);
  assign rsp.product = acc;
  assign rsp.done    = done_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
      cnt    <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        a_reg <= req.a;
        acc   <= {AW'(0), req.b};
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        acc <= {sum, acc[BW-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(BW - 1)) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/stvs_sine_rom.sv -----
// Quarter-wave sine ROM with registered read; address DEPTH reads full scale.
// Entries built at elaboration by a fixed Q30 series. Depends on stvs_pkg.
module stvs_sine_rom #(
  parameter int SINE_TABLE_DEPTH = stvs_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic [$clog2(SINE_TABLE_DEPTH):0]    addr,
  output logic [stvs_pkg::ROM_W-1:0]           data
);

  localparam int AddrW = $clog2(SINE_TABLE_DEPTH) + 1;

  logic [stvs_pkg::ROM_W-1:0] rom [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_entry
    localparam logic [63:0] X  = (stvs_pkg::HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
    localparam logic [63:0] X2 = (X * X) >> 30;
    localparam logic [63:0] T1 = ((X  * X2) >> 30) / 64'd6;
    localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 64'd20;
    localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 64'd42;
    localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 64'd72;
    localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 64'd110;
    localparam logic [63:0] T6 = ((T5 * X2) >> 30) / 64'd156;
    localparam logic [63:0] SUM = X - T1 + T2 - T3 + T4 - T5 + T6;
    localparam logic [63:0] V  = (SUM * 64'd32767 + 64'd536870912) >> 30;
    localparam logic [63:0] VC = (V > 64'(stvs_pkg::SINE_MAX)) ? 64'(stvs_pkg::SINE_MAX) : V;
    assign rom[k] = VC[stvs_pkg::ROM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (addr == AddrW'(SINE_TABLE_DEPTH)) begin
      data <= stvs_pkg::ROM_W'(stvs_pkg::SINE_MAX);
    end else begin
      data <= rom[addr[AddrW-2:0]];
    end
  end

endmodule
